// ----- hdl/rldec_pkg.sv -----
// Shared types and constants for the run-length row pixel decoder.
package rldec_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned FIFO_DEPTH = 4;  // power of two, pointers wrap freely
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_W-1:0] MAX_WIDTH_POS = POS_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(160);

  localparam logic [1:0] OP_SKIP  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [4:0] {
    PH_OPCODE   = 5'b00001,
    PH_RUN      = 5'b00010,
    PH_COLOR_LO = 5'b00100,
    PH_COLOR_HI = 5'b01000,
    PH_ALPHA    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        bad;
    logic [7:0]  alpha;
    logic [15:0] color;
    logic [7:0]  length;
    logic [7:0]  start;
  } span_t;

endpackage

// ----- hdl/rldec_front.sv -----
// Front end: width register, byte parser and span generation.
module rldec_front import rldec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  input  logic             row_first_i,
  output logic             span_valid_o,
  output span_t            span_o
);

  logic [CFG_W-1:0] row_width_q;
  logic [POS_W-1:0] width_eff;

  phase_e           ph_q, ph_d, ph;
  logic [1:0]       op_q, op_d, op;
  logic [7:0]       run_q, run_d, run;
  logic [7:0]       clo_q, clo_d, clo;
  logic [15:0]      color_q, color_d, color;
  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic             halt_q, halt_d, halt;

  logic [POS_W-1:0] room;
  logic [7:0]       len;
  logic             hit;
  span_t            span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
    end else if (cfg_valid_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  assign width_eff = (row_width_q > MAX_WIDTH_POS) ? MAX_WIDTH_POS : row_width_q;

  always_comb begin
    ph    = row_first_i ? PH_OPCODE : ph_q;
    op    = row_first_i ? OP_SKIP : op_q;
    run   = row_first_i ? 8'd0 : run_q;
    clo   = row_first_i ? 8'd0 : clo_q;
    color = row_first_i ? 16'd0 : color_q;
    pos   = row_first_i ? '0 : pos_q;
    halt  = row_first_i ? 1'b0 : halt_q;

    room = width_eff - pos;
    len  = ({1'b0, run} < room) ? run : room[7:0];

    ph_d    = ph;
    op_d    = op;
    run_d   = run;
    clo_d   = clo;
    color_d = color;
    pos_d   = pos;
    halt_d  = halt;
    hit     = 1'b0;
    span    = '0;

    if (!halt && (pos < width_eff)) begin
      unique case (ph)
        PH_OPCODE: begin
          priority if (byte_i == 8'(OP_SKIP) || byte_i == 8'(OP_RUN)) begin
            op_d = byte_i[1:0];
            ph_d = PH_RUN;
          end else if (byte_i == 8'(OP_PIXEL)) begin
            op_d = OP_PIXEL;
            ph_d = PH_COLOR_LO;
          end else begin
            halt_d   = 1'b1;
            hit      = 1'b1;
            span.bad = 1'b1;
            span.start = pos[7:0];
          end
        end
        PH_RUN: begin
          run_d = byte_i;
          if (op == OP_SKIP) begin
            pos_d = pos + {1'b0, byte_i};
            ph_d  = PH_OPCODE;
          end else begin
            ph_d = PH_COLOR_LO;
          end
        end
        PH_COLOR_LO: begin
          clo_d = byte_i;
          ph_d  = PH_COLOR_HI;
        end
        PH_COLOR_HI: begin
          color_d = {byte_i, clo};
          if (op == OP_PIXEL) begin
            ph_d = PH_ALPHA;
          end else begin
            ph_d = PH_OPCODE;
            if (len != 8'd0) begin
              pos_d       = pos + {1'b0, len};
              hit         = 1'b1;
              span.start  = pos[7:0];
              span.length = len;
              span.color  = {byte_i, clo};
              span.alpha  = ALPHA_OPAQUE;
            end
          end
        end
        PH_ALPHA: begin
          ph_d        = PH_OPCODE;
          pos_d       = pos + POS_W'(1);
          hit         = 1'b1;
          span.start  = pos[7:0];
          span.length = 8'd1;
          span.color  = color;
          span.alpha  = byte_i;
        end
        default: begin
          ph_d = PH_OPCODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_OPCODE;
      op_q    <= OP_SKIP;
      run_q   <= '0;
      clo_q   <= '0;
      color_q <= '0;
      pos_q   <= '0;
      halt_q  <= 1'b0;
    end else if (byte_valid_i) begin
      ph_q    <= ph_d;
      op_q    <= op_d;
      run_q   <= run_d;
      clo_q   <= clo_d;
      color_q <= color_d;
      pos_q   <= pos_d;
      halt_q  <= halt_d;
    end
  end

  assign span_valid_o = byte_valid_i && hit;
  assign span_o       = span;

endmodule

// ----- hdl/rldec_fifo.sv -----
// Short span queue between the parser and the output stage.
module rldec_fifo import rldec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  input  span_t wr_data_i,
  output logic  full_o,
  output logic  rd_valid_o,
  output span_t rd_data_o,
  input  logic  rd_pop_i
);

  span_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign push = wr_valid_i && !full_o;
  assign pop  = rd_pop_i && rd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + FIFO_CW'(1);
      2'b01:   cnt_d = cnt_q - FIFO_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign full_o     = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

// ----- hdl/rldec_back.sv -----
// Back end: output register that drives the span word onto the master stream.
module rldec_back import rldec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  span_t       in_span_i,
  output logic        in_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser
);

  logic  valid_q;
  span_t span_q;
  logic  load;

  assign load     = !valid_q || m_axis_tready;
  assign in_pop_o = in_valid_i && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      span_q <= in_span_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {span_q.alpha, span_q.color, span_q.length, span_q.start};
  assign m_axis_tuser  = span_q.bad;

endmodule

// ----- hdl/rle_row_pixel_decoder.sv -----
// Top level of the run-length row pixel decoder.
//
//   channel  dir  handshake                      content
//   s_axis   in   s_axis_tvalid/s_axis_tready    one byte of the row stream
//   m_axis   out  m_axis_tvalid/m_axis_tready    one decoded span word
//   cfg      in   cfg_valid_i/cfg_ready_o        row_width (9 bits)
//
// One byte per cycle while the span queue is not full; the parser updates its state in the cycle the byte is taken.
// A span word passes through the span queue and then the output register before it shows on m_axis.
// A 4-entry span queue plus the output register decouple the two sides;
// s_axis stalls only when the queue is full.
// Reset clears the parser and sets row_width to 160; cfg is always ready.
module rle_row_pixel_decoder import rldec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tuser,   // [0] row_first
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] span_start, [15:8] span_length,
                                           // [31:16] pixel_color, [39:32] pixel_alpha
  output logic             m_axis_tuser    // [0] bad_opcode
);

  logic  fifo_full, byte_acc;
  logic  span_valid, q_valid, q_pop;
  span_t span, q_span;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !fifo_full;
  assign byte_acc      = s_axis_tvalid && s_axis_tready;

  rldec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata),
    .row_first_i  (s_axis_tuser),
    .span_valid_o (span_valid),
    .span_o       (span)
  );

  rldec_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (span_valid),
    .wr_data_i  (span),
    .full_o     (fifo_full),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_span),
    .rd_pop_i   (q_pop)
  );

  rldec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_span_i     (q_span),
    .in_pop_o      (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- hdl/rldec_checker.sv -----
// Port-level assertions for the decoder, bound to the top level.
module rldec_checker import rldec_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [39:0]      m_axis_tdata,
  input logic             m_axis_tuser
);

  // stalled word stays up
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // error word carries no span
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[39:8] == 32'd0)
    else $error("error word with span payload");

  // good span is never empty
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] != 8'd0)
    else $error("empty span emitted");

  // multi-pixel spans come only from opaque runs
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:8] > 8'd1 |->
      m_axis_tdata[39:32] == ALPHA_OPAQUE && !m_axis_tuser)
    else $error("multi-pixel span not opaque");

endmodule

bind rle_row_pixel_decoder rldec_checker u_rldec_checker (.*);

// ----- tb/tb_rle_row_pixel_decoder.sv -----
// Self-checking testbench for the run-length row pixel decoder: directed and random byte streams.
module tb_rle_row_pixel_decoder;
  import rldec_pkg::*;

  localparam int unsigned LIMIT = 200000;
  localparam int DIR_N = 27;
  localparam int N_PHASE = 7;
  localparam int PHASE_W [N_PHASE] = '{8, 1, 256, 0, 511, 160, 0};
  localparam span_t NO_SPAN = '0;

  // sp fields: bad, alpha, color, length, start
  typedef struct packed {
    logic [7:0] b;
    logic       f;
    logic       typed;
    logic       hit;
    span_t      sp;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h01, 1'b1, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{1'b0, 8'd255, 16'hFF00, 8'd160, 8'd0}},
    '{8'hAB, 1'b0, 1'b1, 1'b0, NO_SPAN},
    '{8'h02, 1'b1, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{1'b0, 8'd0, 16'hFFFF, 8'd1, 8'd0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, 1'b1, 1'b0, NO_SPAN},
    '{8'h03, 1'b1, 1'b1, 1'b1, '{1'b1, 8'd0, 16'd0, 8'd0, 8'd0}},
    '{8'h02, 1'b0, 1'b1, 1'b0, NO_SPAN},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_SPAN},
    '{8'h05, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 8'd0, 16'd0, 8'd0, 8'd5}},
    '{8'h01, 1'b1, 1'b0, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h34, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h12, 1'b0, 1'b1, 1'b0, NO_SPAN},
    '{8'h02, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h55, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h01, 1'b1, 1'b0, 1'b0, NO_SPAN},
    '{8'h07, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_SPAN},
    '{8'h80, 1'b0, 1'b0, 1'b0, NO_SPAN}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;
  logic             m_axis_tuser;

  // decoder mirror
  logic [CFG_W-1:0] width_q;
  phase_e           ph_q;
  logic [1:0]       op_q;
  logic [7:0]       run_q;
  logic [7:0]       lo_q;
  logic [15:0]      color_q;
  logic [POS_W-1:0] pos_q;
  logic             halt_q;

  span_t       span_q [$];
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned n_taken = 0;
  int unsigned n_used = 0;
  bit          calm = 1'b0;

  rle_row_pixel_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_row();
    ph_q = PH_OPCODE;
    op_q = OP_SKIP;
    run_q = '0;
    lo_q = '0;
    color_q = '0;
    pos_q = '0;
    halt_q = 1'b0;
  endfunction

  // Advances the mirror by one byte; returns 1 when the byte completes a span word.
  function automatic bit decode_byte(input logic [7:0] b, input logic f,
                                     output span_t sp, output bit used);
    logic [POS_W-1:0] eff;
    logic [POS_W-1:0] room;
    logic [7:0]       len;
    sp = '0;
    used = 1'b0;
    eff = (width_q > MAX_WIDTH_POS) ? MAX_WIDTH_POS : width_q;
    if (f) clear_row();
    if (halt_q || pos_q >= eff) return 1'b0;
    used = 1'b1;
    case (ph_q)
      PH_OPCODE: begin
        if (b == 8'(OP_SKIP) || b == 8'(OP_RUN)) begin
          op_q = b[1:0];
          ph_q = PH_RUN;
        end else if (b == 8'(OP_PIXEL)) begin
          op_q = OP_PIXEL;
          ph_q = PH_COLOR_LO;
        end else begin
          halt_q = 1'b1;
          sp = '{bad: 1'b1, alpha: '0, color: '0, length: '0, start: pos_q[7:0]};
          return 1'b1;
        end
      end
      PH_RUN: begin
        run_q = b;
        if (op_q == OP_SKIP) begin
          pos_q = pos_q + POS_W'(b);
          ph_q = PH_OPCODE;
        end else begin
          ph_q = PH_COLOR_LO;
        end
      end
      PH_COLOR_LO: begin
        lo_q = b;
        ph_q = PH_COLOR_HI;
      end
      PH_COLOR_HI: begin
        color_q = {b, lo_q};
        if (op_q == OP_PIXEL) begin
          ph_q = PH_ALPHA;
          return 1'b0;
        end
        ph_q = PH_OPCODE;
        room = eff - pos_q;
        len = (POS_W'(run_q) < room) ? run_q : room[7:0];
        if (len == '0) return 1'b0;
        sp = '{bad: 1'b0, alpha: ALPHA_OPAQUE, color: color_q, length: len,
               start: pos_q[7:0]};
        pos_q = pos_q + POS_W'(len);
        return 1'b1;
      end
      PH_ALPHA: begin
        ph_q = PH_OPCODE;
        sp = '{bad: 1'b0, alpha: b, color: color_q, length: 8'd1, start: pos_q[7:0]};
        pos_q = pos_q + POS_W'(1);
        return 1'b1;
      end
      default: ph_q = PH_OPCODE;
    endcase
    return 1'b0;
  endfunction

  task automatic chk_field(input string nm, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : mon
    span_t got;
    span_t pred;
    bit    hit;
    bit    used;
    if (!rst_ni) begin
      width_q = ROW_WIDTH_RST;
      clear_row();
    end else begin
      if (cfg_valid_i && cfg_ready_o) width_q = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (span_q.size() == 0) begin
          $display("%0t: unexpected span word, expected none, actual %h", $time, got);
          err_cnt++;
        end else begin
          pred = span_q.pop_front();
          chk_field("span_start", pred.start, got.start);
          chk_field("span_length", pred.length, got.length);
          chk_field("pixel_color", pred.color, got.color);
          chk_field("pixel_alpha", pred.alpha, got.alpha);
          chk_field("bad_opcode", pred.bad, got.bad);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        hit = decode_byte(s_axis_tdata, s_axis_tuser, pred, used);
        if (used) n_used++;
        if (n_taken < DIR_N && DIR_TAB[n_taken].typed) begin
          hit = DIR_TAB[n_taken].hit;
          pred = DIR_TAB[n_taken].sp;
        end
        if (hit) span_q.push_back(pred);
        n_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic f);
    while (!calm && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= f;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] run_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 12));
  endfunction

  // one row: mostly well-formed instructions, some bad opcodes and cut-off ones
  task automatic send_row();
    int   n_ins;
    int   kind;
    logic first;
    n_ins = $urandom_range(1, 6);
    first = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < n_ins; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        push_byte(8'(OP_SKIP), first);
        push_byte(run_byte(), 1'b0);
      end else if (kind < 60) begin
        push_byte(8'(OP_RUN), first);
        push_byte(run_byte(), 1'b0);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b0);
      end else if (kind < 90) begin
        push_byte(8'(OP_PIXEL), first);
        repeat (3) push_byte(8'($urandom), 1'b0);
      end else if (kind < 95) begin
        push_byte(8'($urandom_range(3, 255)), first);
      end else begin
        push_byte(8'($urandom_range(0, 2)), first);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
        return;
      end
      first = 1'b0;
    end
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned      base;
    logic [CFG_W-1:0] w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_N; i++) push_byte(DIR_TAB[i].b, DIR_TAB[i].f);
    for (int k = 0; k < N_PHASE; k++) begin
      w = (k == N_PHASE - 1) ? CFG_W'($urandom_range(2, 255)) : CFG_W'(PHASE_W[k]);
      set_width(w);
      calm <= (w == CFG_W'(256));
      if (w == '0) begin
        repeat (3) send_row();
      end else begin
        base = n_used;
        while (n_used - base < 55) send_row();
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
